FILE: hdl/ccpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccpd_pkg
// Shared types, codes and the CRC-8 byte step for the packet deframer.
// ----------------------------------------------------------------------------
package ccpd_pkg;

	// Default raw store depth in 7-bit entries.
	localparam int RAW_DEPTH_DEFAULT = 64;

	// Register reset values.
	localparam logic [7:0] START_CODE_RESET = 8'd128;
	localparam logic [7:0] END_CODE_RESET   = 8'd129;

	// Register indexes on the configuration port.
	localparam logic REG_START_CODE = 1'b0;
	localparam logic REG_END_CODE   = 1'b1;

	// Reflected CRC-8 polynomial and seed.
	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [7:0] CRC_INIT = 8'h00;

	// Result kinds.
	localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
	localparam logic [2:0] KIND_GOOD_END = 3'd1;
	localparam logic [2:0] KIND_CRC_ERR  = 3'd2;
	localparam logic [2:0] KIND_LEN_ERR  = 3'd3;
	localparam logic [2:0] KIND_BAD_CMD  = 3'd4;
	localparam logic [2:0] KIND_NO_START = 3'd5;

	// Control word for the shared CRC unit.
	typedef struct packed {
		logic clear;
		logic step;
	} crc_ctl_t;

	// One byte through the reflected CRC, least significant bit first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		logic [7:0] d;
		logic       fb;
		c = crc_in;
		d = data;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[0];
			c  = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/ccpd_crc_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccpd_crc_unit
// Shared CRC-8 accumulator: one stored byte is folded in per step.
// ----------------------------------------------------------------------------
module ccpd_crc_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ccpd_pkg::crc_ctl_t  ctl,
	input  wire  [7:0]          din,
	output logic [7:0]          crc
);
	import ccpd_pkg::*;

	logic [7:0] crc_q;

	// Accumulator register: clear to the seed, or fold in one byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.clear) begin
			crc_q <= CRC_INIT;
		end else if (ctl.step) begin
			crc_q <= crc8_byte(crc_q, din);
		end
	end

	assign crc = crc_q;

endmodule
`default_nettype wire

FILE: hdl/crc8_checked_packet_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_checked_packet_deframer
// Frames 7-bit serial bytes into packets, checks the CRC-8 at the end code
// and emits the unpacked payload words followed by a status word.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  input     in_valid, in_ready, rx_byte               into the block
//  output    out_valid, out_ready, kind, value, last   out of the block
//  config    psel, penable, pwrite, paddr, pwdata,     APB slave
//            prdata, pready
//
// A data, start or unknown command word is handled in the idle state alone.
// An end code over a good-length packet runs the CRC pass (read, accumulate
// per entry before the check pair), then the check pair, then each payload
// pair, through the single read port of the raw store feeding the shared CRC
// unit; payload words also wait on out_ready. The next input word is taken
// once the sequencer is idle and the output register is free or draining.
// Reset clears all control state; the raw store holds no reset value.
// ----------------------------------------------------------------------------
module crc8_checked_packet_deframer #(
	parameter int RAW_DEPTH = ccpd_pkg::RAW_DEPTH_DEFAULT
) (
	input  wire         clk,
	input  wire         arst_n,
	// Input channel
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  rx_byte,
	// Output channel
	output logic        out_valid,
	input  wire         out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  value,
	output logic        last,
	// Configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ccpd_pkg::*;

	localparam int CNT_W  = $clog2(RAW_DEPTH + 1);
	localparam int ADDR_W = $clog2(RAW_DEPTH);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_CRC_RD    = 7'b0000010,
		S_CRC_ACC   = 7'b0000100,
		S_PAIR_LO   = 7'b0001000,
		S_PAIR_HI   = 7'b0010000,
		S_PAIR_USE  = 7'b0100000,
		S_EMIT_WAIT = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [7:0]        start_code_q;
	logic [7:0]        end_code_q;
	logic              in_packet_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  chk_pos_q;
	logic              chk_mode_q;
	logic [6:0]        lo_q;
	logic [6:0]        rd_data_q;
	logic              out_valid_q;
	logic [2:0]        kind_q;
	logic [7:0]        value_q;
	logic              last_q;

	logic [6:0]        raw_mem [RAW_DEPTH];

	logic              accept_in;
	logic              out_fire;
	logic              cfg_we;
	logic              is_data;
	logic              is_start;
	logic              is_end;
	logic              len_bad;
	logic              store_full;
	logic              mem_we;
	logic              begin_check;
	logic [CNT_W-1:0]  rd_ptr;
	logic [7:0]        pair_byte;
	logic [7:0]        crc_val;
	crc_ctl_t          crc_ctl;

	// Handshakes and decode of the incoming word.
	assign accept_in   = in_valid && in_ready;
	assign out_fire    = out_valid_q && out_ready;
	assign cfg_we      = psel && penable && pwrite && pready;
	assign is_data     = !rx_byte[7];
	assign is_start    = (rx_byte == start_code_q);
	assign is_end      = (rx_byte == end_code_q);
	assign store_full  = (cnt_q >= CNT_W'(RAW_DEPTH));
	assign len_bad     = ovf_q || (cnt_q < CNT_W'(2)) || cnt_q[0];
	assign mem_we      = accept_in && is_data && in_packet_q && !store_full;
	assign begin_check = accept_in && !is_data && !is_start && is_end && in_packet_q
		&& !len_bad;
	assign in_ready    = (state_q == S_IDLE) && (!out_valid_q || out_ready);

	// Configuration read side.
	assign pready = 1'b1;
	always_comb begin
		prdata = 32'd0;
		unique case (paddr[2])
			REG_START_CODE: prdata = {24'd0, start_code_q};
			REG_END_CODE:   prdata = {24'd0, end_code_q};
			default:        prdata = 32'd0;
		endcase
	end

	// Raw store: written while a packet is open, read one entry per cycle.
	assign rd_ptr = (state_q == S_PAIR_HI) ? (ptr_q + CNT_W'(1)) : ptr_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			raw_mem[cnt_q[ADDR_W-1:0]] <= rx_byte[6:0];
		end
		rd_data_q <= raw_mem[rd_ptr[ADDR_W-1:0]];
	end

	// Shared CRC unit over the stored entries.
	assign crc_ctl.clear = begin_check;
	assign crc_ctl.step  = (state_q == S_CRC_ACC);

	ccpd_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.din    ({1'b0, rd_data_q}),
		.crc    (crc_val)
	);

	// Unpacked byte: low seven bits of the first entry, bit 0 of the second.
	assign pair_byte = {rd_data_q[0], lo_q};

	// Sequencer, packet state, configuration registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			start_code_q <= START_CODE_RESET;
			end_code_q   <= END_CODE_RESET;
			in_packet_q  <= 1'b0;
			ovf_q        <= 1'b0;
			cnt_q        <= '0;
			ptr_q        <= '0;
			chk_pos_q    <= '0;
			chk_mode_q   <= 1'b0;
			lo_q         <= '0;
			out_valid_q  <= 1'b0;
			kind_q       <= KIND_PAYLOAD;
			value_q      <= 8'd0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (paddr[2])
					REG_START_CODE: start_code_q <= pwdata[7:0];
					REG_END_CODE:   end_code_q   <= pwdata[7:0];
					default:        ;
				endcase
			end

			if (out_fire) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						if (is_data) begin
							if (in_packet_q) begin
								if (!store_full) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
						end else if (is_start) begin
							in_packet_q <= 1'b1;
							cnt_q       <= '0;
							ovf_q       <= 1'b0;
						end else begin
							// Any other command closes the packet.
							in_packet_q <= 1'b0;
							cnt_q       <= '0;
							ovf_q       <= 1'b0;
							if (!is_end) begin
								out_valid_q <= 1'b1;
								kind_q      <= KIND_BAD_CMD;
								value_q     <= rx_byte;
								last_q      <= 1'b1;
							end else if (!in_packet_q) begin
								out_valid_q <= 1'b1;
								kind_q      <= KIND_NO_START;
								value_q     <= rx_byte;
								last_q      <= 1'b1;
							end else if (len_bad) begin
								out_valid_q <= 1'b1;
								kind_q      <= KIND_LEN_ERR;
								value_q     <= 8'd0;
								last_q      <= 1'b1;
							end else begin
								ptr_q      <= '0;
								chk_pos_q  <= cnt_q - CNT_W'(2);
								chk_mode_q <= 1'b1;
								state_q    <= (cnt_q == CNT_W'(2)) ? S_PAIR_LO : S_CRC_RD;
							end
						end
					end
				end
				S_CRC_RD: begin
					state_q <= S_CRC_ACC;
				end
				S_CRC_ACC: begin
					ptr_q <= ptr_q + CNT_W'(1);
					if (ptr_q + CNT_W'(1) == chk_pos_q) begin
						state_q <= S_PAIR_LO;
					end else begin
						state_q <= S_CRC_RD;
					end
				end
				S_PAIR_LO: begin
					state_q <= S_PAIR_HI;
				end
				S_PAIR_HI: begin
					lo_q    <= rd_data_q;
					state_q <= S_PAIR_USE;
				end
				S_PAIR_USE: begin
					if (chk_mode_q) begin
						// Check pair against the accumulated CRC.
						if (pair_byte != crc_val) begin
							out_valid_q <= 1'b1;
							kind_q      <= KIND_CRC_ERR;
							value_q     <= 8'd0;
							last_q      <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							chk_mode_q <= 1'b0;
							ptr_q      <= '0;
							if (chk_pos_q == '0) begin
								out_valid_q <= 1'b1;
								kind_q      <= KIND_GOOD_END;
								value_q     <= 8'd0;
								last_q      <= 1'b1;
								state_q     <= S_IDLE;
							end else begin
								state_q <= S_PAIR_LO;
							end
						end
					end else begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_PAYLOAD;
						value_q     <= pair_byte;
						last_q      <= 1'b0;
						ptr_q       <= ptr_q + CNT_W'(2);
						state_q     <= S_EMIT_WAIT;
					end
				end
				S_EMIT_WAIT: begin
					if (out_fire) begin
						if (ptr_q == chk_pos_q) begin
							out_valid_q <= 1'b1;
							kind_q      <= KIND_GOOD_END;
							value_q     <= 8'(chk_pos_q >> 1);
							last_q      <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_PAIR_LO;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign last      = last_q;

	// The packet is always closed while the sequencer walks the store.
	a_closed_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_packet_q && cnt_q == '0)
		else $error("packet open while the sequencer is busy");

	// The CRC pass always stops exactly at the check pair.
	a_check_at_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PAIR_LO && chk_mode_q |-> ptr_q == chk_pos_q)
		else $error("check pair read at the wrong position");

	// The fill count never runs past the store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(RAW_DEPTH))
		else $error("raw count beyond store depth");

	// A payload word is never the last word of a packet.
	a_payload_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_PAYLOAD |-> !last_q)
		else $error("payload word marked last");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CRC-8 checked packet deframer. A behavioral
// predictor tracks the raw store, packet state and command codes, and queues
// the words each accepted byte should produce. Directed frames cover the
// command cases and the store limits. Random traffic then runs under several
// code settings and several patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import ccpd_pkg::*;

	localparam int STORE_DEPTH = RAW_DEPTH_DEFAULT;
	// Settle time after draining: the CRC pass over a full store, plus margin.
	localparam int SETTLE_CYCLES = 2 * (STORE_DEPTH - 2) + 3 * STORE_DEPTH / 2 + 16;
	localparam int STALL_LIMIT = 10000;
	localparam int MAX_REPORTS = 10;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic       last;
	} deframe_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  value;
	logic        last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	crc8_checked_packet_deframer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.value(value),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Predictor state: a mirror of the deframer and its command codes.
	logic [6:0]  raw_mem [STORE_DEPTH];
	int          raw_fill = 0;
	bit          pkt_open = 1'b0;
	bit          store_over = 1'b0;
	logic [7:0]  cfg_start = START_CODE_RESET;
	logic [7:0]  cfg_end = END_CODE_RESET;

	deframe_word_t pending_words[$];
	int send_idle_pct = 36;
	int recv_stall_pct = 72;
	int error_count = 0;
	int fed_words = 0;
	int checked_words = 0;
	int good_frames = 0;
	int stall_cycles = 0;

	// Reflected CRC-8, whole byte folded in, then eight shifts.
	function automatic logic [7:0] crc8_reflected(input logic [7:0] acc, input logic [7:0] data);
		logic [7:0] r;
		r = acc ^ data;
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	// Work out the words one accepted byte causes and queue them.
	task automatic deframe_byte(input logic [7:0] b);
		deframe_word_t words[$];
		deframe_word_t w;
		logic [7:0] crc;
		logic [7:0] check;
		int n_pay;
		if (!b[7]) begin
			// Data outside a packet is ignored and not counted.
			if (!pkt_open) begin
				return;
			end
			fed_words++;
			if (raw_fill < STORE_DEPTH) begin
				raw_mem[raw_fill] = b[6:0];
				raw_fill++;
			end else begin
				store_over = 1'b1;
			end
			return;
		end
		fed_words++;
		if (b == cfg_start) begin
			pkt_open = 1'b1;
			raw_fill = 0;
			store_over = 1'b0;
			return;
		end
		if (b == cfg_end) begin
			if (!pkt_open) begin
				words.insert(words.size(), deframe_word_t'{KIND_NO_START, b, 1'b0});
			end else if (store_over || raw_fill < 2 || raw_fill % 2 != 0) begin
				words.insert(words.size(), deframe_word_t'{KIND_LEN_ERR, 8'd0, 1'b0});
			end else begin
				crc = CRC_INIT;
				for (int i = 0; i < raw_fill - 2; i++) begin
					crc = crc8_reflected(crc, {1'b0, raw_mem[i]});
				end
				check = {raw_mem[raw_fill - 1][0], raw_mem[raw_fill - 2]};
				if (crc == check) begin
					n_pay = raw_fill / 2 - 1;
					for (int i = 0; i < n_pay; i++) begin
						words.insert(words.size(), deframe_word_t'{KIND_PAYLOAD,
							{raw_mem[2 * i + 1][0], raw_mem[2 * i]}, 1'b0});
					end
					words.insert(words.size(),
						deframe_word_t'{KIND_GOOD_END, 8'(n_pay), 1'b0});
				end else begin
					words.insert(words.size(), deframe_word_t'{KIND_CRC_ERR, 8'd0, 1'b0});
				end
			end
		end else begin
			words.insert(words.size(), deframe_word_t'{KIND_BAD_CMD, b, 1'b0});
		end
		// End codes and other commands always close the packet.
		pkt_open = 1'b0;
		raw_fill = 0;
		store_over = 1'b0;
		for (int k = 0; k < words.size(); k++) begin
			w = words[k];
			w.last = (k == words.size() - 1);
			pending_words.insert(pending_words.size(), w);
		end
	endtask

	// Send one byte, with a random gap first; valid stays high on return.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		deframe_byte(b);
	endtask

	// Hold the sender off until every expected word has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// Drain, then give the end-code pass time to finish before touching registers.
	task automatic quiesce();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [7:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {24'd0, data};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_codes(input logic [7:0] start_val, input logic [7:0] end_val);
		quiesce();
		write_reg({REG_START_CODE, 2'b00}, start_val);
		cfg_start = start_val;
		write_reg({REG_END_CODE, 2'b00}, end_val);
		cfg_end = end_val;
	endtask

	function automatic byte_q_t random_payload(input int n);
		byte_q_t q;
		for (int i = 0; i < n; i++) q.insert(q.size(), 8'($urandom));
		return q;
	endfunction

	// Pack a payload into 7-bit pairs with its check pair and send it as a frame.
	task automatic send_frame(input byte_q_t payload, input bit corrupt);
		byte_q_t raw;
		logic [7:0] crc;
		int idx;
		crc = CRC_INIT;
		foreach (payload[i]) begin
			raw.insert(raw.size(), {1'b0, payload[i][6:0]});
			raw.insert(raw.size(), {1'b0, 6'($urandom), payload[i][7]});
		end
		foreach (raw[i]) crc = crc8_reflected(crc, raw[i]);
		raw.insert(raw.size(), {1'b0, crc[6:0]});
		raw.insert(raw.size(), {1'b0, 6'($urandom), crc[7]});
		if (corrupt) begin
			idx = $urandom_range(0, raw.size() - 1);
			raw[idx] = raw[idx] ^ 8'(1 << $urandom_range(0, 6));
		end
		send_byte(cfg_start);
		foreach (raw[i]) send_byte(raw[i]);
		send_byte(cfg_end);
	endtask

	// Receiver stalls at the rate of the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Check each output word against the oldest expectation.
	always @(posedge clk) begin
		deframe_word_t want;
		if (arst_n && out_valid && out_ready) begin
			checked_words++;
			if (pending_words.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("Unexpected word: kind=%0d value=%02h last=%0b",
						kind, value, last);
				end
			end else begin
				want = pending_words.pop_front();
				if (kind !== want.kind || value !== want.value || last !== want.last) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("Mismatch: expected kind=%0d value=%02h last=%0b",
							want.kind, want.value, want.last,
							", got kind=%0d value=%02h last=%0b",
							kind, value, last);
					end
				end else if (want.kind == KIND_GOOD_END) begin
					good_frames++;
				end
			end
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Command cases, extremes of the byte, and the basic error paths.
	task automatic test_directed_cases();
		byte_q_t extremes;
		extremes.insert(extremes.size(), 8'h00);
		extremes.insert(extremes.size(), 8'hFF);
		// Data outside a packet is dropped silently; an end code without a start and an unknown command are reported.
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(END_CODE_RESET);
		send_byte(8'hFF);
		// A second start restarts the packet.
		send_byte(START_CODE_RESET);
		send_byte(8'h33);
		send_frame(extremes, 1'b0);
		// Empty packet and odd raw count are length errors.
		send_byte(START_CODE_RESET);
		send_byte(END_CODE_RESET);
		send_byte(START_CODE_RESET);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);
		send_byte(END_CODE_RESET);
		// Check byte 0x80 against a CRC of zero.
		send_byte(START_CODE_RESET);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(END_CODE_RESET);
		wait_drained();
	endtask

	// A frame that fills the store exactly, and one that overflows it.
	task automatic test_store_limits();
		send_frame(random_payload(STORE_DEPTH / 2 - 1), 1'b0);
		send_frame(random_payload(STORE_DEPTH / 2), 1'b0);
	endtask

	// Mostly well-formed frames, with corrupt frames, aborts and noise.
	task automatic test_random_traffic(input int n_words);
		int goal;
		int pick;
		int len;
		goal = fed_words + n_words;
		while (fed_words < goal) begin
			pick = $urandom_range(0, 99);
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, STORE_DEPTH / 2)
				: $urandom_range(0, 6);
			if (pick < 55) begin
				send_frame(random_payload(len), 1'b0);
			end else if (pick < 65) begin
				send_frame(random_payload(len), 1'b1);
			end else if (pick < 75) begin
				// Broken frame followed by an arbitrary command.
				send_byte(cfg_start);
				repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 127)));
				send_byte(8'($urandom_range(128, 255)));
			end else if (pick < 97) begin
				send_byte(8'($urandom));
			end else begin
				wait_drained();
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles lightly, receiver heavily, reset codes.
		send_idle_pct = 36;
		recv_stall_pct = 72;
		test_directed_cases();
		test_store_limits();
		test_random_traffic(80);

		// Codes at the opposite extremes, stall pattern swapped.
		set_codes(8'd255, 8'd128);
		send_idle_pct = 72;
		recv_stall_pct = 36;
		test_random_traffic(80);

		// Start equal to end: the byte always opens a packet.
		set_codes(8'd200, 8'd200);
		test_random_traffic(20);

		// No stalls on either side.
		set_codes(8'd129, 8'd255);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(60);

		quiesce();
		$display("Sent %0d bytes under four code settings and three stall patterns.",
			fed_words);
		$display("Checked %0d output words, %0d good frames, %0d errors.",
			checked_words, good_frames, error_count);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: crc8_checked_packet_deframer.f
hdl/ccpd_pkg.sv
hdl/ccpd_crc_unit.sv
hdl/crc8_checked_packet_deframer.sv
tb/testbench.sv
